### rtl/core/hlw_pkg.sv
// Shared types, character codes and the hex digit decoder for the hex line parser.
// Has no dependencies; every module of the block imports it.
package hlw_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned VALUE_W  = 60;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned ERR_W    = 2;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_INVALID  = 3'd2,
    ST_TOO_MANY = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  // Line error codes share their encoding with the low bits of status_t.
  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_INVALID  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_TOO_MANY = 2'd3;

  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   value;
    logic [COUNT_W-1:0]   digit_count;
  } result_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] nibble;
  } nibble_t;

  function automatic nibble_t hex_decode(input logic [CHAR_W-1:0] c);
    nibble_t r;
    r.is_hex = 1'b1;
    r.nibble = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r.nibble = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      r.nibble = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      r.nibble = 4'(c - 8'h37);
    end else begin
      r.is_hex = 1'b0;
    end
    return r;
  endfunction

endpackage

### rtl/core/hlw_in_stage.sv
// Input register of the hex line parser: holds one received word until the line logic takes it.
// Depends on hlw_pkg.
module hlw_in_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [hlw_pkg::CHAR_W-1:0] in_char_code,
  output logic                       in_stall,
  input  logic                       advance,
  output logic                       s1_valid,
  output logic [hlw_pkg::CHAR_W-1:0] s1_char
);
  import hlw_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic [CHAR_W-1:0] s1_char_r;
  logic              load;

  // The stage is free when empty or when its word moves on this cycle.
  assign in_stall = s1_valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_char_r <= in_char_code;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_char  = s1_char_r;

endmodule

### rtl/core/hlw_line.sv
// Line state and per-character parse logic of the hex line parser.
// Depends on hlw_pkg.
module hlw_line #(
  parameter int unsigned LINE_MAX   = 32,
  parameter int unsigned MAX_DIGITS = 15
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [hlw_pkg::CHAR_W-1:0] char_code,
  output logic                       res_valid,
  output hlw_pkg::result_t           res
);
  import hlw_pkg::*;

  localparam int unsigned LW = (LINE_MAX > 2) ? $clog2(LINE_MAX) : 1;
  localparam int unsigned DW = $clog2(MAX_DIGITS + 1);
  localparam logic [LW-1:0] LEN_LAST  = LW'(LINE_MAX - 1);
  localparam logic [DW-1:0] DIGIT_MAX = DW'(MAX_DIGITS);

  logic [VALUE_W-1:0] accum_r,     accum_nxt;
  logic [DW-1:0]      digits_r,    digits_nxt;
  logic [LW-1:0]      len_r,       len_nxt;
  logic               leading_r,   leading_nxt;
  logic [ERR_W-1:0]   err_r,       err_nxt;
  logic               ended_r,     ended_nxt;

  logic    is_eol;
  logic    is_blank;
  logic    clear;
  nibble_t nib;
  logic [4:0] digits_wide;

  assign is_eol   = (char_code == CHAR_CR) || (char_code == CHAR_LF);
  assign is_blank = (char_code == CHAR_SPACE) || (char_code == CHAR_TAB);
  assign nib      = hex_decode(char_code);
  assign digits_wide = 5'(digits_r);

  always_comb begin
    accum_nxt   = accum_r;
    digits_nxt  = digits_r;
    len_nxt     = len_r;
    leading_nxt = leading_r;
    err_nxt     = err_r;
    ended_nxt   = ended_r;
    clear       = 1'b0;
    res_valid   = 1'b0;
    res.status      = ST_OK;
    res.value       = '0;
    res.digit_count = digits_wide[COUNT_W-1:0];

    if (is_eol) begin
      if (len_r != '0) begin
        res_valid = 1'b1;
        clear     = 1'b1;
        if (err_r != ERR_NONE) begin
          res.status = status_t'({1'b0, err_r});
        end else if (leading_r) begin
          res.status = ST_EMPTY;
        end else begin
          res.value = accum_r;
        end
      end
    end else if (len_r < LEN_LAST) begin
      len_nxt = len_r + 1'b1;
      if (!ended_r) begin
        if (char_code == CHAR_NUL) begin
          ended_nxt = 1'b1;
        end else if (!(leading_r && is_blank)) begin
          leading_nxt = 1'b0;
          if (err_r == ERR_NONE) begin
            if (!nib.is_hex) begin
              err_nxt = ERR_INVALID;
            end else if (digits_r >= DIGIT_MAX) begin
              err_nxt = ERR_TOO_MANY;
            end else begin
              accum_nxt  = {accum_r[VALUE_W-5:0], nib.nibble};
              digits_nxt = digits_r + 1'b1;
            end
          end
        end
      end
    end else begin
      // The character that would fill the line is dropped.
      res_valid  = 1'b1;
      clear      = 1'b1;
      res.status = ST_OVERFLOW;
    end

    if (clear) begin
      accum_nxt   = '0;
      digits_nxt  = '0;
      len_nxt     = '0;
      leading_nxt = 1'b1;
      err_nxt     = ERR_NONE;
      ended_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r   <= '0;
      digits_r  <= '0;
      len_r     <= '0;
      leading_r <= 1'b1;
      err_r     <= ERR_NONE;
      ended_r   <= 1'b0;
    end else if (step) begin
      accum_r   <= accum_nxt;
      digits_r  <= digits_nxt;
      len_r     <= len_nxt;
      leading_r <= leading_nxt;
      err_r     <= err_nxt;
      ended_r   <= ended_nxt;
    end
  end

endmodule

### rtl/core/hlw_out_stage.sv
// Result register of the hex line parser, with the downstream valid/stall handshake.
// Depends on hlw_pkg.
module hlw_out_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        res_load,
  input  hlw_pkg::result_t            res,
  output logic                        advance,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hlw_pkg::STATUS_W-1:0] out_status,
  output logic [hlw_pkg::VALUE_W-1:0]  out_value,
  output logic [hlw_pkg::COUNT_W-1:0]  out_digit_count
);
  import hlw_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  result_t res_r;

  // Upstream may move when this register is empty or is being emptied.
  assign advance = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = res_r.status;
  assign out_value       = res_r.value;
  assign out_digit_count = res_r.digit_count;

endmodule

### rtl/core/hex_line_to_60bit_word_unit.sv
// Hex line parser: one received character word in, one result word per non-empty line out.
// The result register loads each result as the word ending its line leaves the input register.
// Throughput: one word per cycle unless out_stall holds a result; both registers hold one word.
// Reset (rst_n, synchronous, active low) empties both registers and starts a fresh line.
// No clearing pass follows reset; the block takes words in the first cycle after it.
// Depends on hlw_pkg, hlw_in_stage, hlw_line and hlw_out_stage.
module hex_line_to_60bit_word_unit #(
  parameter int unsigned LINE_MAX   = 32,
  parameter int unsigned MAX_DIGITS = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [hlw_pkg::CHAR_W-1:0]   in_char_code,
  output logic                         in_stall,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hlw_pkg::STATUS_W-1:0] out_status,
  output logic [hlw_pkg::VALUE_W-1:0]  out_value,
  output logic [hlw_pkg::COUNT_W-1:0]  out_digit_count
);
  import hlw_pkg::*;

  // The word held in the input register moves into the line logic whenever
  // the result register can take whatever result it causes. The line state
  // is updated in that same cycle, so consecutive characters are handled
  // back to back without bubbles.
  logic              advance;
  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              step;
  logic              res_valid;
  result_t           res;

  hlw_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_char_code (in_char_code),
    .in_stall     (in_stall),
    .advance      (advance),
    .s1_valid     (s1_valid),
    .s1_char      (s1_char)
  );

  assign step = s1_valid && advance;

  // Line state: value, digit count, length, blank skipping, sticky error and
  // the end-of-text flag set by a zero byte.
  hlw_line #(
    .LINE_MAX   (LINE_MAX),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .char_code (s1_char),
    .res_valid (res_valid),
    .res       (res)
  );

  hlw_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_load        (step && res_valid),
    .res             (res),
    .advance         (advance),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_value       (out_value),
    .out_digit_count (out_digit_count)
  );

  // The input side only stalls when a word is waiting behind a held result.
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a held result");

  // Only an ok result carries a value.
  a_value_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_value == '0))
    else $error("non-ok result carries a value");

  // Reset leaves no result pending.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
